FILE: rtl/core/tsr_pkg.sv
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared widths, controller states and the command and status bundles that
// pass between the reassembler controller and its datapath.
// ----------------------------------------------------------------------------
package tsr_pkg;

  // Fixed field widths
  localparam int POS_W  = 64;  // absolute stream positions and totals
  localparam int BYTE_W = 8;   // one stream byte
  localparam int CNT_W  = 7;   // capacity, pending and room counts

  localparam logic [CNT_W-1:0] CAP_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_WRITE,
    ST_READ,
    ST_EMIT,
    ST_STATUS
  } tsr_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load_in;      // capture the accepted input transaction
    logic calc;         // evaluate window position and room
    logic write;        // store the byte, update end index and segment state
    logic pop;          // take the head byte out of the store
    logic emit_byte;    // load a data result into the output register
    logic emit_status;  // load a status result into the output register
  } tsr_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic closed;    // stream already closed
    logic empty;     // captured item is an empty segment
    logic can_pop;   // head byte present and room left
    logic out_free;  // output register can take a result this cycle
  } tsr_sts_t;

endpackage

FILE: rtl/core/tsr_ctrl.sv
// ----------------------------------------------------------------------------
// tsr_ctrl
// Sequencer for the reassembler: walks one input transaction through window
// evaluation, store update and the drain of the contiguous run.
// ----------------------------------------------------------------------------
module tsr_ctrl
  import tsr_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tsr_sts_t sts_i,
  output tsr_cmd_t cmd_o
);

  tsr_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.closed ? ST_STATUS : ST_CALC;
        end
      end
      ST_CALC:  state_d = ST_WRITE;
      ST_WRITE: state_d = sts_i.empty ? ST_STATUS : ST_READ;
      ST_READ:  state_d = sts_i.can_pop ? ST_EMIT : ST_STATUS;
      ST_EMIT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.can_pop ? ST_READ : ST_IDLE;
        end
      end
      ST_STATUS: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      ST_CALC:   cmd_o.calc        = 1'b1;
      ST_WRITE:  cmd_o.write       = 1'b1;
      ST_READ:   cmd_o.pop         = sts_i.can_pop;
      ST_EMIT:   cmd_o.emit_byte   = sts_i.out_free;
      ST_STATUS: cmd_o.emit_status = sts_i.out_free;
      default: begin
        cmd_o      = '0;
        in_stall_o = 1'b1;
      end
    endcase
  end

  a_pop_needs_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.pop |-> sts_i.can_pop)
    else $error("pop issued without a present head byte and room");

  a_one_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o))
    else $error("more than one datapath command in a cycle");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_byte || cmd_o.emit_status) |-> sts_i.out_free)
    else $error("result loaded while output register is occupied");

endmodule

FILE: rtl/core/tsr_dpath.sv
// ----------------------------------------------------------------------------
// tsr_dpath
// Reassembler datapath: input capture, window arithmetic, ring store with
// presence bits, stream counters, end tracking and the output register.
// ----------------------------------------------------------------------------
module tsr_dpath
  import tsr_pkg::*;
#(
  parameter int STORE_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsr_cmd_t          cmd_i,
  output tsr_sts_t          sts_o,
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  input  logic [POS_W-1:0]  byte_index_i,
  input  logic [BYTE_W-1:0] byte_value_i,
  input  logic              empty_segment_i,
  input  logic              segment_end_i,
  input  logic              fin_i,
  input  logic [POS_W-1:0]  popped_total_i,
  output logic              res_valid_o,
  input  logic              res_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_valid_o,
  output logic              run_last_o,
  output logic [POS_W-1:0]  pushed_count_o,
  output logic [CNT_W-1:0]  pending_count_o,
  output logic              stream_closed_o
);

  localparam int SLOT_W = $clog2(STORE_DEPTH);
  localparam int SUM_W  = CNT_W + 1;
  localparam logic [CNT_W-1:0]  DEPTH_C  = CNT_W'(STORE_DEPTH);
  localparam logic [SUM_W-1:0]  DEPTH_S  = SUM_W'(STORE_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(STORE_DEPTH - 1);

  // Captured input transaction
  logic [POS_W-1:0]  idx_q, popped_q;
  logic [BYTE_W-1:0] val_q;
  logic              empty_q, seg_end_q, fin_q;

  // Window evaluation results
  logic              idx_ok_q, idx_ok_d;
  logic [CNT_W-1:0]  diff_q, diff_d;
  logic [CNT_W-1:0]  room_q, room_d;
  logic [CNT_W-1:0]  ahead_q, ahead_d;

  // Stream state
  logic [CNT_W-1:0]       cap_q;
  logic [STORE_DEPTH-1:0] present_q, present_d;
  logic [BYTE_W-1:0]      store_q [STORE_DEPTH];
  logic [BYTE_W-1:0]      rd_q;
  logic [POS_W-1:0]       pushed_q, pushed_d;
  logic [CNT_W-1:0]       held_q, held_d;
  logic [SLOT_W-1:0]      head_q, head_d;
  logic [POS_W-1:0]       end_q, end_d;
  logic                   end_known_q, end_known_d;
  logic                   closed_q, closed_d;
  logic                   hit_q, hit_d;

  // Output register
  logic              res_valid_q, res_valid_d;
  logic [BYTE_W-1:0] ob_q;
  logic              ov_q, last_q, oclosed_q;
  logic [POS_W-1:0]  opushed_q;
  logic [CNT_W-1:0]  oheld_q;

  logic [CNT_W-1:0]  cap_eff;
  logic [POS_W:0]    diff_full, pp_full;
  logic [POS_W-1:0]  unread_full;
  logic              ahead_pos, unread_ok;
  logic [CNT_W-1:0]  unread7;
  logic [SUM_W-1:0]  slot_sum, slot_wrap;
  logic [SLOT_W-1:0] slot;
  logic              in_win, store_new, raise_req;
  logic [POS_W-1:0]  end_cand;
  logic              can_pop, done_now, out_free;

  assign cap_eff  = (cap_q > DEPTH_C) ? DEPTH_C : cap_q;
  assign can_pop  = (room_q != '0) && present_q[head_q];
  assign done_now = end_known_q && (end_q == pushed_q);
  assign out_free = !res_valid_q || !res_stall_i;

  assign sts_o.closed   = closed_q;
  assign sts_o.empty    = empty_q;
  assign sts_o.can_pop  = can_pop;
  assign sts_o.out_free = out_free;

  // Window position and room left, all relative to the pushed total
  always_comb begin
    diff_full   = {1'b0, idx_q} - {1'b0, pushed_q};
    pp_full     = {1'b0, popped_q} - {1'b0, pushed_q};
    unread_full = pushed_q - popped_q;
    ahead_pos   = !pp_full[POS_W] && (pp_full[POS_W-1:0] != '0);
    unread_ok   = ahead_pos || (unread_full[POS_W-1:CNT_W] == '0);
    unread7     = ahead_pos ? '0 : unread_full[CNT_W-1:0];

    idx_ok_d = !diff_full[POS_W] && (diff_full[POS_W-1:CNT_W] == '0);
    diff_d   = diff_full[CNT_W-1:0];
    room_d   = (unread_ok && (unread7 < cap_eff)) ? (cap_eff - unread7) : '0;
    if (!ahead_pos) begin
      ahead_d = '0;
    end else if (pp_full[POS_W-1:CNT_W] != '0) begin
      ahead_d = '1;
    end else begin
      ahead_d = pp_full[CNT_W-1:0];
    end
  end

  // Ring slot: head plus offset, folded once into the store depth
  always_comb begin
    slot_sum  = SUM_W'(head_q) + {1'b0, diff_q};
    slot_wrap = (slot_sum >= DEPTH_S) ? (slot_sum - DEPTH_S) : slot_sum;
    slot      = slot_wrap[SLOT_W-1:0];
    in_win    = !empty_q && idx_ok_q && (diff_q < room_q);
    store_new = in_win && !present_q[slot];
    end_cand  = idx_q + {{(POS_W-1){1'b0}}, !empty_q};
    raise_req = empty_q ? fin_q : (seg_end_q && fin_q && (in_win || hit_q));
  end

  // Stream state update
  always_comb begin
    present_d   = present_q;
    pushed_d    = pushed_q;
    held_d      = held_q;
    head_d      = head_q;
    end_d       = end_q;
    end_known_d = end_known_q;
    closed_d    = closed_q;
    hit_d       = hit_q;
    room_d_hold: begin end
    if (cmd_i.write) begin
      if (store_new) begin
        present_d[slot] = 1'b1;
        held_d          = held_q + 1'b1;
      end
      if (raise_req) begin
        if (!end_known_q || (end_cand > end_q)) begin
          end_d = end_cand;
        end
        end_known_d = 1'b1;
      end
      if (empty_q || seg_end_q) begin
        hit_d = 1'b0;
      end else if (in_win) begin
        hit_d = 1'b1;
      end
    end
    if (cmd_i.pop) begin
      present_d[head_q] = 1'b0;
      held_d            = held_q - 1'b1;
      pushed_d          = pushed_q + 1'b1;
      head_d            = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
    end
    // Close only at the final result of a transaction
    if (cmd_i.emit_status || (cmd_i.emit_byte && !can_pop)) begin
      closed_d = done_now;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_i.emit_byte || cmd_i.emit_status) begin
      res_valid_d = 1'b1;
    end else if (!res_stall_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      present_q   <= '0;
      pushed_q    <= '0;
      held_q      <= '0;
      head_q      <= '0;
      end_q       <= '0;
      end_known_q <= 1'b0;
      closed_q    <= 1'b0;
      hit_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      present_q   <= present_d;
      pushed_q    <= pushed_d;
      held_q      <= held_d;
      head_q      <= head_d;
      end_q       <= end_d;
      end_known_q <= end_known_d;
      closed_q    <= closed_d;
      hit_q       <= hit_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      idx_q     <= byte_index_i;
      val_q     <= byte_value_i;
      empty_q   <= empty_segment_i;
      seg_end_q <= segment_end_i;
      fin_q     <= fin_i;
      popped_q  <= popped_total_i;
    end
    if (cmd_i.calc) begin
      idx_ok_q <= idx_ok_d;
      diff_q   <= diff_d;
      room_q   <= room_d;
      ahead_q  <= ahead_d;
    end else if (cmd_i.pop) begin
      // While the reader is ahead, a push does not use up room
      if (ahead_q != '0) begin
        ahead_q <= ahead_q - 1'b1;
      end else begin
        room_q <= room_q - 1'b1;
      end
    end
    if (cmd_i.emit_byte || cmd_i.emit_status) begin
      ob_q      <= cmd_i.emit_byte ? rd_q : '0;
      ov_q      <= cmd_i.emit_byte;
      last_q    <= cmd_i.emit_status || !can_pop;
      opushed_q <= pushed_q;
      oheld_q   <= held_q;
      oclosed_q <= done_now;
    end
  end

  // Ring store
  always_ff @(posedge clk_i) begin
    if (cmd_i.write && store_new) begin
      store_q[slot] <= val_q;
    end
    if (cmd_i.pop) begin
      rd_q <= store_q[head_q];
    end
  end

  assign res_valid_o     = res_valid_q;
  assign out_byte_o      = ob_q;
  assign out_valid_o     = ov_q;
  assign run_last_o      = last_q;
  assign pushed_count_o  = opushed_q;
  assign pending_count_o = oheld_q;
  assign stream_closed_o = oclosed_q;

  a_held_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q == CNT_W'($countones(present_q)))
    else $error("held count out of step with presence bits");

  a_closed_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    closed_q |=> closed_q)
    else $error("closed stream reopened");

endmodule

FILE: rtl/core/tcp_stream_reassembler_top.sv
// ----------------------------------------------------------------------------
// tcp_stream_reassembler_top
// Rebuilds an in-order byte stream from out-of-order, overlapping segment
// bytes, one byte transaction at a time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one byte with its absolute
//   stream index, or an empty-segment marker, plus the reader's popped total.
//   Output channel (res_valid_o / res_stall_i) returns, per input transaction,
//   either the run of newly contiguous bytes (one transaction per byte,
//   run_last_o on the final one) or a single status transaction.
//   cfg_we_i / cfg_wdata_i set the stream capacity; write it only while idle.
// Sequencing:
//   The input is taken in the idle state. A byte transaction then passes through
//   window arithmetic (three 64-bit subtracts), the store update and end-index
//   compare, then a registered store read and an output load for each pushed
//   byte; with no byte pushed it ends in a status result. Empty segments pass
//   the same two steps to a status result; a closed stream goes straight to one.
// Reset clears presence bits, counters and end tracking at once; no sweep of
// the store is needed. A stalled receiver holds the output register and the
// drain waits on it; in_stall_o stays high until the transaction is done.
// ----------------------------------------------------------------------------
module tcp_stream_reassembler_top
  import tsr_pkg::*;
#(
  parameter int STORE_DEPTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration
  input  logic              cfg_we_i,
  input  logic [CNT_W-1:0]  cfg_wdata_i,
  // input channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [POS_W-1:0]  byte_index_i,
  input  logic [BYTE_W-1:0] byte_value_i,
  input  logic              empty_segment_i,
  input  logic              segment_end_i,
  input  logic              fin_i,
  input  logic [POS_W-1:0]  popped_total_i,
  // output channel
  output logic              res_valid_o,
  input  logic              res_stall_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_valid_o,
  output logic              run_last_o,
  output logic [POS_W-1:0]  pushed_count_o,
  output logic [CNT_W-1:0]  pending_count_o,
  output logic              stream_closed_o
);

  tsr_cmd_t cmd;
  tsr_sts_t sts;

  // Sequence each transaction: evaluate, store, then drain the run
  tsr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Hold the ring store, counters and output register
  tsr_dpath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .byte_index_i    (byte_index_i),
    .byte_value_i    (byte_value_i),
    .empty_segment_i (empty_segment_i),
    .segment_end_i   (segment_end_i),
    .fin_i           (fin_i),
    .popped_total_i  (popped_total_i),
    .res_valid_o     (res_valid_o),
    .res_stall_i     (res_stall_i),
    .out_byte_o      (out_byte_o),
    .out_valid_o     (out_valid_o),
    .run_last_o      (run_last_o),
    .pushed_count_o  (pushed_count_o),
    .pending_count_o (pending_count_o),
    .stream_closed_o (stream_closed_o)
  );

endmodule
